/* rtl/bb3_pkg.sv */
// Shared constants for the 3x3 RGB box blur block.
package bb3_pkg;

  // Default frame store dimensions
  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;

  // Configuration register indexes
  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  // Request kinds carried on tuser
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // Q0.16 tap weights: 0.111 off center, 0.112 at the center
  localparam logic [12:0] WeightEdge   = 13'd7274;
  localparam logic [12:0] WeightCenter = 13'd7340;

  // Channel limits and accumulator width (9 * 255 * 7340 < 2**25)
  localparam logic [7:0] ChannelMax = 8'd255;
  localparam int         AccWidth   = 25;

  // Configuration register reset and width
  localparam int          DimRegWidth = 9;
  localparam logic [8:0]  DimRegReset = 9'd256;

endpackage

/* rtl/rgb_box_blur_3x3.sv */
// 3x3 box blur over an RGB frame held in a single-port synchronous memory.
// Write request: stored at the accept edge if x and y lie inside the store, no result; the
//   next request can be taken in the next cycle. Query request: nine reads, one per cycle
//   through the single memory port, then a truncating sum; the result enters the output
//   register from StDone, and StIdle takes the next request; a waiting result stalls StDone.
// Reset clears control state and sets both dimensions to 256; frame contents stay undefined.
module rgb_box_blur_3x3 #(
  parameter int MAX_WIDTH  = bb3_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = bb3_pkg::MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: x[7:0], y[15:8], in_red[23:16], in_green[31:24], in_blue[39:32]
  input  logic [39:0] s_axis_tdata,
  // tuser: req_type[0]
  input  logic        s_axis_tuser,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic [23:0] m_axis_tdata
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int LW    = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
  localparam int LH    = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
  localparam int AccW  = bb3_pkg::AccWidth;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StLast = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [8:0]  width_q, height_q;
  logic [7:0]  cx_q, cy_q;
  logic [1:0]  col_q, col_d, row_q, row_d;
  logic        rd_vld_q, rd_center_q;
  logic [AccW-1:0] acc_r_q, acc_g_q, acc_b_q;
  logic [AccW-1:0] acc_r_d, acc_g_d, acc_b_d;
  logic        out_vld_q;
  logic [23:0] out_data_q;

  logic [23:0] mem_q [Depth];
  logic [23:0] rd_data_q;

  logic        req_acc, is_write, is_query, wr_in_range;
  logic [7:0]  req_x, req_y;
  logic [LW-1:0] lim_x, nx;
  logic [LH-1:0] lim_y, ny;
  logic [8:0]  sx, sy;
  logic [AW-1:0] wr_addr, rd_addr;
  logic        mem_we, mem_re;
  logic [12:0] weight;
  logic        out_free;

  assign req_x    = s_axis_tdata[7:0];
  assign req_y    = s_axis_tdata[15:8];
  assign req_acc  = s_axis_tvalid && s_axis_tready;
  assign is_write = req_acc && (s_axis_tuser == bb3_pkg::ReqWrite);
  assign is_query = req_acc && (s_axis_tuser == bb3_pkg::ReqQuery);
  assign s_axis_tready = (state_q == StIdle);
  assign out_free = !out_vld_q || m_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bb3_pkg::DimRegReset;
      height_q <= bb3_pkg::DimRegReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bb3_pkg::RegImageWidth) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
    end
  end

  // Last usable column and row: zero acts as one, large values cap at the store size
  always_comb begin
    if (width_q == 9'd0) begin
      lim_x = '0;
    end else if (LW'(width_q) > LW'(MAX_WIDTH)) begin
      lim_x = LW'(MAX_WIDTH - 1);
    end else begin
      lim_x = LW'(width_q) - LW'(1);
    end
    if (height_q == 9'd0) begin
      lim_y = '0;
    end else if (LH'(height_q) > LH'(MAX_HEIGHT)) begin
      lim_y = LH'(MAX_HEIGHT - 1);
    end else begin
      lim_y = LH'(height_q) - LH'(1);
    end
  end

  // Neighbor coordinates, clamped into the image in use
  always_comb begin
    if (cx_q == 8'd0 && col_q == 2'd0) begin
      sx = 9'd0;
    end else begin
      sx = {1'b0, cx_q} + {7'd0, col_q} - 9'd1;
    end
    if (cy_q == 8'd0 && row_q == 2'd0) begin
      sy = 9'd0;
    end else begin
      sy = {1'b0, cy_q} + {7'd0, row_q} - 9'd1;
    end
    nx = (LW'(sx) > lim_x) ? lim_x : LW'(sx);
    ny = (LH'(sy) > lim_y) ? lim_y : LH'(sy);
  end

  // Memory addresses for the read sweep and for incoming writes
  assign rd_addr = AW'(ny) * AW'(MAX_WIDTH) + AW'(nx);
  assign wr_addr = AW'(req_y) * AW'(MAX_WIDTH) + AW'(req_x);
  assign wr_in_range = (LW'(req_x) < LW'(MAX_WIDTH)) && (LH'(req_y) < LH'(MAX_HEIGHT));
  assign mem_we = is_write && wr_in_range;
  assign mem_re = (state_q == StRead);

  // Frame store: one port, write or read per cycle; red high, blue low
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};
    end else if (mem_re) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Sequencer: walk the nine taps, then finish the sum and hand it off
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    case (state_q)
      StIdle: begin
        if (is_query) begin
          state_d = StRead;
          col_d   = 2'd0;
          row_d   = 2'd0;
        end
      end
      StRead: begin
        if (row_q == 2'd2) begin
          row_d = 2'd0;
          if (col_q == 2'd2) begin
            state_d = StLast;
          end else begin
            col_d = col_q + 2'd1;
          end
        end else begin
          row_d = row_q + 2'd1;
        end
      end
      StLast: state_d = StDone;
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      col_q       <= 2'd0;
      row_q       <= 2'd0;
      rd_vld_q    <= 1'b0;
      rd_center_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      rd_vld_q    <= mem_re;
      rd_center_q <= mem_re && (col_q == 2'd1) && (row_q == 2'd1);
    end
  end

  // Hold the query center
  always_ff @(posedge clk_i) begin
    if (is_query) begin
      cx_q <= req_x;
      cy_q <= req_y;
    end
  end

  // Accumulate weighted channels as read data returns
  assign weight = rd_center_q ? bb3_pkg::WeightCenter : bb3_pkg::WeightEdge;

  always_comb begin
    acc_r_d = acc_r_q;
    acc_g_d = acc_g_q;
    acc_b_d = acc_b_q;
    if (is_query) begin
      acc_r_d = '0;
      acc_g_d = '0;
      acc_b_d = '0;
    end else if (rd_vld_q) begin
      acc_r_d = acc_r_q + AccW'(rd_data_q[23:16]) * AccW'(weight);
      acc_g_d = acc_g_q + AccW'(rd_data_q[15:8]) * AccW'(weight);
      acc_b_d = acc_b_q + AccW'(rd_data_q[7:0]) * AccW'(weight);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_r_q <= acc_r_d;
    acc_g_q <= acc_g_d;
    acc_b_q <= acc_b_d;
  end

  // Drop the fraction and saturate one channel
  function automatic logic [7:0] bb3_round(input logic [AccW-1:0] acc);
    logic [AccW-17:0] whole;
    whole = acc[AccW-1:16];
    if (whole > (AccW-16)'(bb3_pkg::ChannelMax)) begin
      return bb3_pkg::ChannelMax;
    end
    return whole[7:0];
  endfunction

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == StDone && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && out_free) begin
      out_data_q <= {bb3_round(acc_b_q), bb3_round(acc_g_q), bb3_round(acc_r_q)};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
